// ----- src/moon_phase_from_date_defines.svh -----
// ----------------------------------------------------------------------------
// Moon phase assertion macros
// Shared concurrent assertion forms for the moon phase block.
// ----------------------------------------------------------------------------
`ifndef MOON_PHASE_FROM_DATE_DEFINES_SVH
`define MOON_PHASE_FROM_DATE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MPFD_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("moon phase assertion failed");

// next-cycle implication, disabled in reset
`define MPFD_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("moon phase assertion failed");

`endif

// ----- src/mpfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Moon phase package
// Constants, step counts and the arctangent table of the moon phase block.
// ----------------------------------------------------------------------------
package mpfd_pkg;

   localparam int KEPLER_STEPS = 6;
   localparam int CORDIC_STEPS = 24;

   // angles are turns / 2^32, daily rates turns/day with 40 fraction bits
   localparam logic [63:0] EPOCH_Q24 = 64'd4888477 << 23;
   localparam logic [63:0] RATE_SUN  = ((64'd1 << 40) * 64'd10000 + 64'd1826211) / 64'd3652422;
   localparam logic [63:0] RATE_MOON = ((64'd65881983 << 36) + 64'd56250000) / 64'd112500000;
   localparam logic [63:0] RATE_PERI = ((64'd1114041 << 36) + 64'd112500000) / 64'd225000000;
   localparam logic [63:0] SYN_Q24   = ((64'd2953058868 << 24) + 64'd50000000) / 64'd100000000;

   localparam logic [63:0] SUN_LON0_W   = ((64'd278833540 << 32) + 64'd180000000) / 64'd360000000;
   localparam logic [63:0] SUN_PERI_W   = ((64'd282596403 << 32) + 64'd180000000) / 64'd360000000;
   localparam logic [63:0] MOON_LON0_W  = ((64'd64975464 << 32) + 64'd180000000) / 64'd360000000;
   localparam logic [63:0] MOON_PERI0_W = ((64'd349383063 << 32) + 64'd180000000) / 64'd360000000;
   localparam logic [63:0] AMP_EVECT_W  = ((64'd1273900 << 32) + 64'd180000000) / 64'd360000000;
   localparam logic [63:0] AMP_ANNUAL_W = ((64'd185800 << 32) + 64'd180000000) / 64'd360000000;
   localparam logic [63:0] AMP_THIRD_W  = ((64'd370000 << 32) + 64'd180000000) / 64'd360000000;
   localparam logic [63:0] AMP_CENTRE_W = ((64'd6288600 << 32) + 64'd180000000) / 64'd360000000;
   localparam logic [63:0] AMP_FOURTH_W = ((64'd214000 << 32) + 64'd180000000) / 64'd360000000;
   localparam logic [63:0] AMP_VAR_W    = ((64'd658300 << 32) + 64'd180000000) / 64'd360000000;

   localparam logic [31:0] SUN_LON0   = SUN_LON0_W[31:0];
   localparam logic [31:0] SUN_PERI   = SUN_PERI_W[31:0];
   localparam logic [31:0] MOON_LON0  = MOON_LON0_W[31:0];
   localparam logic [31:0] MOON_PERI0 = MOON_PERI0_W[31:0];

   localparam logic [31:0] ECC_Q30     = 32'd17951013;
   localparam logic [31:0] ECC_TURNS   = 32'd11427844;
   localparam logic [31:0] SQRT1E2_Q30 = 32'd1073591763;
   localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

   function automatic logic [31:0] atan_turns(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0: r = 32'd536870912;
         5'd1: r = 32'd316933406;
         5'd2: r = 32'd167458907;
         5'd3: r = 32'd85004756;
         5'd4: r = 32'd42667331;
         5'd5: r = 32'd21354465;
         5'd6: r = 32'd10679838;
         5'd7: r = 32'd5340245;
         5'd8: r = 32'd2670163;
         5'd9: r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         5'd24: r = 32'd41;
         5'd25: r = 32'd20;
         5'd26: r = 32'd10;
         5'd27: r = 32'd5;
         5'd28: r = 32'd3;
         5'd29: r = 32'd1;
         5'd30: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- src/moon_phase_from_date.sv -----
// ----------------------------------------------------------------------------
// Moon phase from date
// Julian date in, phase position, illuminated fraction and age of the Moon out.
// ----------------------------------------------------------------------------
// One date is taken at a time. Most of the work of a date is done in the
// shared CORDIC stage (one micro-rotation per cycle, fourteen runs per date)
// and in the restoring divider of the Newton steps.
// One 33 x 33 signed multiplier serves every product, its result registered.
// req_tready is high only while the sequencer is idle; a finished result sits
// in the output register, so the next date can be taken while it waits.
// Any 48-bit date is valid, dates before 1980.0 included.
`include "moon_phase_from_date_defines.svh"

module moon_phase_from_date (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [47:0] julian_date
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // [15:0] cycle_position, [32:16] illuminated_fraction,
                                    // [53:33] moon_age, [55:54] zero
);
   import mpfd_pkg::*;

   // sequencer codes
   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_RATE   = 5'd1;
   localparam logic [4:0] ST_CORDIC = 5'd2;
   localparam logic [4:0] ST_KM1    = 5'd3;
   localparam logic [4:0] ST_KM2    = 5'd4;
   localparam logic [4:0] ST_KM3    = 5'd5;
   localparam logic [4:0] ST_KDIV   = 5'd6;
   localparam logic [4:0] ST_KUPD   = 5'd7;
   localparam logic [4:0] ST_EM     = 5'd8;
   localparam logic [4:0] ST_VSET   = 5'd9;
   localparam logic [4:0] ST_LS     = 5'd10;
   localparam logic [4:0] ST_EVM    = 5'd11;
   localparam logic [4:0] ST_EVP    = 5'd12;
   localparam logic [4:0] ST_AEM    = 5'd13;
   localparam logic [4:0] ST_AEP    = 5'd14;
   localparam logic [4:0] ST_A3P    = 5'd15;
   localparam logic [4:0] ST_CEM    = 5'd16;
   localparam logic [4:0] ST_CEP    = 5'd17;
   localparam logic [4:0] ST_FOM    = 5'd18;
   localparam logic [4:0] ST_FOP    = 5'd19;
   localparam logic [4:0] ST_VAM    = 5'd20;
   localparam logic [4:0] ST_VAP    = 5'd21;
   localparam logic [4:0] ST_FIN    = 5'd22;
   localparam logic [4:0] ST_AGM    = 5'd23;

   localparam logic [5:0] CRD_LAST = 6'(CORDIC_STEPS - 1);
   localparam logic [5:0] DIV_LAST = 6'd35;
   localparam logic [4:0] KEP_LAST = 5'(KEPLER_STEPS - 1);

   // fold an angle into +-1/4 turn, flag the half-turn flip
   function automatic logic [34:0] fold(input logic [31:0] ang);
      logic signed [33:0] z;
      logic               f;
      z = {{2{ang[31]}}, ang};
      f = 1'b0;
      if (z > 34'sd1073741824) begin
         z = z - 34'sd2147483648;
         f = 1'b1;
      end else if (z < -34'sd1073741824) begin
         z = z + 34'sd2147483648;
         f = 1'b1;
      end
      return {f, z};
   endfunction

   logic [4:0]         state_ff, state_in, ret_ff, ret_in;
   logic [5:0]         i_ff, i_in;
   logic [4:0]         n_ff, n_in;
   logic [1:0]         rsel_ff, rsel_in;
   logic               vec_ff, vec_in, flip_ff, flip_in;
   logic signed [35:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [33:0] cz_ff, cz_in;
   logic [63:0]        day_ff, day_in;
   logic [31:0]        acc_ff, acc_in;
   logic signed [65:0] p_ff, p_in;
   logic [31:0]        m_ff, m_in, e_ff, e_in, ls_ff, ls_in, ml_ff, ml_in, mm_ff, mm_in;
   logic [31:0]        ev_ff, ev_in, ae_ff, ae_in, mmp_ff, mmp_in, lp_ff, lp_in;
   logic [31:0]        age_ff, age_in;
   logic               dneg_ff, dneg_in;
   logic [35:0]        dvd_ff, dvd_in;
   logic [30:0]        rem_ff, rem_in, q_ff, q_in;
   logic [31:0]        quo_ff, quo_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [55:0]        rsp_tdata_ff, rsp_tdata_in;

   // combinational working values
   logic signed [32:0] mul_a, mul_b;
   logic               rot_go;
   logic [31:0]        rot_ang;
   logic [4:0]         rot_ret;
   logic [34:0]        rot_fold;
   logic signed [35:0] xs, ys, xv, yv;
   logic signed [33:0] at, emsx, pk, dv, absd, qv;
   logic               dir;
   logic [63:0]        rate;
   logic [31:0]        asum, delta, t_ang, sinp;
   logic [31:0]        tq;
   logic [32:0]        tdiff;
   logic               ge;
   logic signed [36:0] iv;
   logic [36:0]        rr;
   logic [16:0]        ill;
   logic [63:0]        mage_w;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;  i_in = i_ff;  n_in = n_ff;
      rsel_in = rsel_ff;  vec_in = vec_ff;  flip_in = flip_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  cz_in = cz_ff;
      day_in = day_ff;  acc_in = acc_ff;
      m_in = m_ff;  e_in = e_ff;  ls_in = ls_ff;  ml_in = ml_ff;  mm_in = mm_ff;
      ev_in = ev_ff;  ae_in = ae_ff;  mmp_in = mmp_ff;  lp_in = lp_ff;  age_in = age_ff;
      dneg_in = dneg_ff;  dvd_in = dvd_ff;  rem_in = rem_ff;  q_in = q_ff;  quo_in = quo_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in = rsp_tdata_ff;
      mul_a = '0;  mul_b = '0;
      rot_go = 1'b0;  rot_ang = '0;  rot_ret = ST_IDLE;

      // shared datapath terms
      xs    = cx_ff >>> i_ff[4:0];
      ys    = cy_ff >>> i_ff[4:0];
      at    = {2'b00, atan_turns(i_ff[4:0])};
      dir   = vec_ff ? cy_ff[35] : ~cz_ff[33];
      sinp  = p_ff[61:30];
      pk    = p_ff[63:30];
      case (rsel_ff)
         2'd0:    rate = RATE_SUN;
         2'd1:    rate = RATE_MOON;
         default: rate = RATE_PERI;
      endcase
      asum  = acc_ff + p_ff[31:0];
      emsx  = {{2{e_ff[31] ^ m_ff[31] ^ (e_ff < m_ff)}}, 32'(e_ff - m_ff)};
      emsx  = {{2{emsx[31]}}, emsx[31:0]};
      dv    = emsx - pk;
      absd  = dv[33] ? -dv : dv;
      qv    = 34'sd1073741824 - pk;
      tq    = {rem_ff, dvd_ff[35]};
      tdiff = {1'b0, tq} - {2'b00, q_ff};
      ge    = ~tdiff[32];
      delta = dneg_ff ? 32'(-quo_ff) : quo_ff;
      xv    = cx_ff - 36'sd17951013;
      yv    = p_ff[65:30];
      t_ang = '0;
      iv    = 37'sd1073741824 - {cx_ff[35], cx_ff};
      rr    = 37'(iv[36] ? 37'sd0 : iv) + 37'd16384;
      rr    = rr >> 15;
      ill   = (rr > 37'd65536) ? 17'd65536 : rr[16:0];
      mage_w = p_ff[63:0] + (64'd1 << 39);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               day_in   = {16'd0, req_tdata} - EPOCH_Q24;
               rsel_in  = 2'd0;
               i_in     = '0;
               state_in = ST_RATE;
            end
         end
         // bits 32..63 of day * rate: lo*lo high half, plus two cross terms
         ST_RATE: begin
            i_in = i_ff + 6'd1;
            case (i_ff[1:0])
               2'd0: begin
                  mul_a = {1'b0, day_ff[31:0]};
                  mul_b = {1'b0, rate[31:0]};
               end
               2'd1: begin
                  acc_in = p_ff[63:32];
                  mul_a  = {1'b0, day_ff[63:32]};
                  mul_b  = {1'b0, rate[31:0]};
               end
               2'd2: begin
                  acc_in = asum;
                  mul_a  = {1'b0, day_ff[31:0]};
                  mul_b  = {1'b0, rate[63:32]};
               end
               default: begin
                  i_in = '0;
                  case (rsel_ff)
                     2'd0: begin
                        m_in    = asum + SUN_LON0 - SUN_PERI;
                        rsel_in = 2'd1;
                     end
                     2'd1: begin
                        ml_in   = asum + MOON_LON0;
                        rsel_in = 2'd2;
                     end
                     default: begin
                        mm_in   = ml_ff - asum - MOON_PERI0;
                        e_in    = m_ff;
                        n_in    = '0;
                        rot_go  = 1'b1;
                        rot_ang = m_ff;
                        rot_ret = ST_KM1;
                     end
                  endcase
               end
            endcase
         end
         ST_CORDIC: begin
            i_in = i_ff + 6'd1;
            if (dir) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - at;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + at;
            end
            if (i_ff == CRD_LAST) begin
               if (flip_ff) begin
                  cx_in = -cx_in;
                  cy_in = -cy_in;
               end
               state_in = ret_ff;
            end
         end
         // Newton step on Kepler's equation
         ST_KM1: begin
            mul_a    = {1'b0, ECC_TURNS};
            mul_b    = cy_ff[32:0];
            state_in = ST_KM2;
         end
         ST_KM2: begin
            dneg_in  = dv[33];
            rem_in   = {3'b000, absd[33:6]};
            dvd_in   = {absd[5:0], 30'd0};
            mul_a    = {1'b0, ECC_Q30};
            mul_b    = cx_ff[32:0];
            state_in = ST_KM3;
         end
         ST_KM3: begin
            q_in     = (qv < 34'sd1) ? 31'd1 : qv[30:0];
            i_in     = '0;
            state_in = ST_KDIV;
         end
         ST_KDIV: begin
            rem_in = ge ? tdiff[30:0] : tq[30:0];
            dvd_in = {dvd_ff[34:0], 1'b0};
            quo_in = {quo_ff[30:0], ge};
            i_in   = i_ff + 6'd1;
            if (i_ff == DIV_LAST) begin
               state_in = ST_KUPD;
            end
         end
         ST_KUPD: begin
            e_in    = e_ff - delta;
            n_in    = n_ff + 5'd1;
            rot_go  = 1'b1;
            rot_ang = e_ff - delta;
            rot_ret = (n_ff == KEP_LAST) ? ST_EM : ST_KM1;
         end
         // true anomaly through vectoring mode
         ST_EM: begin
            mul_a    = {1'b0, SQRT1E2_Q30};
            mul_b    = cy_ff[32:0];
            state_in = ST_VSET;
         end
         ST_VSET: begin
            if (xv[35]) begin
               cx_in = -xv;
               cy_in = -yv;
               cz_in = 34'sd2147483648;
            end else begin
               cx_in = xv;
               cy_in = yv;
               cz_in = '0;
            end
            vec_in   = 1'b1;
            flip_in  = 1'b0;
            i_in     = '0;
            ret_in   = ST_LS;
            state_in = ST_CORDIC;
         end
         ST_LS: begin
            ls_in   = cz_ff[31:0] + SUN_PERI;
            t_ang   = ml_ff - (cz_ff[31:0] + SUN_PERI);
            rot_go  = 1'b1;
            rot_ang = {t_ang[30:0], 1'b0} - mm_ff;
            rot_ret = ST_EVM;
         end
         // lunar correction terms
         ST_EVM: begin
            mul_a    = {1'b0, AMP_EVECT_W[31:0]};
            mul_b    = cy_ff[32:0];
            state_in = ST_EVP;
         end
         ST_EVP: begin
            ev_in   = sinp;
            rot_go  = 1'b1;
            rot_ang = m_ff;
            rot_ret = ST_AEM;
         end
         ST_AEM: begin
            mul_a    = {1'b0, AMP_ANNUAL_W[31:0]};
            mul_b    = cy_ff[32:0];
            state_in = ST_AEP;
         end
         ST_AEP: begin
            ae_in    = sinp;
            mul_a    = {1'b0, AMP_THIRD_W[31:0]};
            mul_b    = cy_ff[32:0];
            state_in = ST_A3P;
         end
         ST_A3P: begin
            mmp_in  = mm_ff + ev_ff - ae_ff - sinp;
            rot_go  = 1'b1;
            rot_ang = mm_ff + ev_ff - ae_ff - sinp;
            rot_ret = ST_CEM;
         end
         ST_CEM: begin
            mul_a    = {1'b0, AMP_CENTRE_W[31:0]};
            mul_b    = cy_ff[32:0];
            state_in = ST_CEP;
         end
         ST_CEP: begin
            lp_in   = ml_ff + ev_ff + sinp - ae_ff;
            rot_go  = 1'b1;
            rot_ang = {mmp_ff[30:0], 1'b0};
            rot_ret = ST_FOM;
         end
         ST_FOM: begin
            mul_a    = {1'b0, AMP_FOURTH_W[31:0]};
            mul_b    = cy_ff[32:0];
            state_in = ST_FOP;
         end
         ST_FOP: begin
            lp_in   = lp_ff + sinp;
            t_ang   = lp_ff + sinp - ls_ff;
            rot_go  = 1'b1;
            rot_ang = {t_ang[30:0], 1'b0};
            rot_ret = ST_VAM;
         end
         ST_VAM: begin
            mul_a    = {1'b0, AMP_VAR_W[31:0]};
            mul_b    = cy_ff[32:0];
            state_in = ST_VAP;
         end
         ST_VAP: begin
            age_in  = lp_ff + sinp - ls_ff;
            rot_go  = 1'b1;
            rot_ang = lp_ff + sinp - ls_ff;
            rot_ret = ST_AGM;
         end
         // form the age product on the shared multiplier
         ST_AGM: begin
            mul_a    = {1'b0, age_ff};
            mul_b    = {1'b0, SYN_Q24[31:0]};
            state_in = ST_FIN;
         end
         // hold the age product while the output register is still full
         ST_FIN: begin
            mul_a = {1'b0, age_ff};
            mul_b = {1'b0, SYN_Q24[31:0]};
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {2'b00, mage_w[60:40], ill, age_ff[31:16]};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // start a rotation-mode run of the CORDIC stage
      rot_fold = fold(rot_ang);
      if (rot_go) begin
         cx_in    = {4'b0000, CORDIC_GAIN};
         cy_in    = '0;
         cz_in    = rot_fold[33:0];
         flip_in  = rot_fold[34];
         vec_in   = 1'b0;
         i_in     = '0;
         ret_in   = rot_ret;
         state_in = ST_CORDIC;
      end

      p_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in;  i_ff <= i_in;  n_ff <= n_in;  rsel_ff <= rsel_in;
      vec_ff <= vec_in;  flip_ff <= flip_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;  cz_ff <= cz_in;
      day_ff <= day_in;  acc_ff <= acc_in;  p_ff <= p_in;
      m_ff <= m_in;  e_ff <= e_in;  ls_ff <= ls_in;  ml_ff <= ml_in;  mm_ff <= mm_in;
      ev_ff <= ev_in;  ae_ff <= ae_in;  mmp_ff <= mmp_in;  lp_ff <= lp_in;  age_ff <= age_in;
      dneg_ff <= dneg_in;  dvd_ff <= dvd_in;  rem_ff <= rem_in;  q_ff <= q_in;
      quo_ff <= quo_in;  rsp_tdata_ff <= rsp_tdata_in;
   end

   `MPFD_ASSERT_NEXT(a_busy_after_take, req_tvalid && req_tready, !req_tready)
   `MPFD_ASSERT_IMPL(a_div_nonzero, state_ff == ST_KDIV, q_ff != 31'd0)
   `MPFD_ASSERT_IMPL(a_ill_range, rsp_tvalid, rsp_tdata[32:16] <= 17'd65536)
   `MPFD_ASSERT_IMPL(a_kepler_count, state_ff == ST_KUPD, n_ff <= KEP_LAST)

endmodule

// ----- tb/sv/moon_phase_from_date_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Moon phase from date testbench
// Drives Julian dates into the block with random gaps and output stalls,
// predicts phase position, illuminated fraction and age with an independent
// fixed-point Sun/Moon computation, and checks every result transfer in order.
// ----------------------------------------------------------------------------
module moon_phase_from_date_test;
   import mpfd_pkg::*;

   localparam int  ITEM_COUNT   = 1450;
   localparam int  STALL_LIMIT  = 20000;  // cycles with no transfer at all
   localparam int  DRAIN_CYCLES = 700;
   localparam int  IDLE_PCT     = 24;

   localparam longint TURN    = 64'sd4294967296;
   localparam longint HALF    = 64'sd2147483648;
   localparam longint QUARTER = 64'sd1073741824;
   localparam longint UNITY   = 64'sd1073741824;  // 1.0 with 30 fraction bits

   localparam longint ARC_STEP [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
      81, 41, 20, 10, 5, 3, 1, 1, 0};

   typedef struct packed {
      logic [20:0] age_days;
      logic [16:0] lit;
      logic [15:0] position;
   } phase_type;

   // Scoreboard: predicts the phase of each accepted date and holds it until
   // the matching result transfer arrives.
   class phase_scoreboard;
      phase_type phases_due[$];
      int        errors;

      task report(string msg);
         $display("ERROR @%0t: %s", $time, msg);
         errors++;
      endtask

      // rotation CORDIC, argument folded into +-1/4 turn
      function void rotate(input logic [31:0] ang, output longint s, output longint c);
         longint z, x, y, xs, ys;
         bit flip;
         z = longint'(ang);
         x = 652032874;
         y = 0;
         flip = 0;
         if (z >= HALF) z -= TURN;
         if (z > QUARTER) begin
            z -= HALF;
            flip = 1;
         end else if (z < -QUARTER) begin
            z += HALF;
            flip = 1;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> (i & 31);
            ys = y >>> (i & 31);
            if (z >= 0) begin
               x -= ys; y += xs; z -= ARC_STEP[i & 31];
            end else begin
               x += ys; y -= xs; z += ARC_STEP[i & 31];
            end
         end
         s = flip ? -y : y;
         c = flip ? -x : x;
      endfunction

      function longint sine_full(input logic [31:0] ang);
         longint s, c;
         rotate(ang, s, c);
         return s;
      endfunction

      // vectoring CORDIC, result in turns
      function logic [31:0] bearing(input longint y, input longint x);
         longint z, xs, ys;
         z = 0;
         if (x < 0) begin
            x = -x; y = -y; z = HALF;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> (i & 31);
            ys = y >>> (i & 31);
            if (y < 0) begin
               x -= ys; y += xs; z -= ARC_STEP[i & 31];
            end else begin
               x += ys; y -= xs; z += ARC_STEP[i & 31];
            end
         end
         return z[31:0];
      endfunction

      function logic [31:0] daily_angle(input logic [63:0] day, input logic [63:0] rate);
         logic [63:0] p;
         p = day * rate;
         return p[63:32];
      endfunction

      function logic [31:0] amp_term(input logic [63:0] amp, input longint s);
         longint v;
         v = (longint'(amp) * s) >>> 30;
         return v[31:0];
      endfunction

      // Newton iteration on Kepler's equation
      function logic [31:0] eccentric_anomaly(input logic [31:0] mean);
         logic [31:0] e, diff;
         longint s, c, d, q, step;
         e = mean;
         for (int n = 0; n < KEPLER_STEPS; n++) begin
            rotate(e, s, c);
            diff = e - mean;
            d = longint'(diff);
            if (d >= HALF) d -= TURN;
            d -= (longint'(ECC_TURNS) * s) >>> 30;
            q = UNITY - ((longint'(ECC_Q30) * c) >>> 30);
            if (q < 1) q = 1;
            step = (d * UNITY) / q;
            e = e - step[31:0];
         end
         return e;
      endfunction

      function phase_type phase_of(input logic [47:0] jd);
         logic [63:0] day, mage;
         logic [31:0] m, ecc, ls, ml, mm, mmp, lp, lpp, age_ang, ev, ae, a3;
         longint s, c, sm, ill;
         phase_type r;
         day = {16'd0, jd} - EPOCH_Q24;
         m   = daily_angle(day, RATE_SUN) + SUN_LON0 - SUN_PERI;
         ecc = eccentric_anomaly(m);
         rotate(ecc, s, c);
         ls = bearing((longint'(SQRT1E2_Q30) * s) >>> 30, c - longint'(ECC_Q30)) + SUN_PERI;
         ml = daily_angle(day, RATE_MOON) + MOON_LON0;
         mm = ml - daily_angle(day, RATE_PERI) - MOON_PERI0;
         ev = amp_term(AMP_EVECT_W, sine_full(((ml - ls) << 1) - mm));
         sm = sine_full(m);
         ae = amp_term(AMP_ANNUAL_W, sm);
         a3 = amp_term(AMP_THIRD_W, sm);
         mmp = mm + ev - ae - a3;
         lp = ml + ev + amp_term(AMP_CENTRE_W, sine_full(mmp)) - ae
            + amp_term(AMP_FOURTH_W, sine_full(mmp << 1));
         lpp = lp + amp_term(AMP_VAR_W, sine_full((lp - ls) << 1));
         age_ang = lpp - ls;
         rotate(age_ang, s, c);
         ill = UNITY - c;
         if (ill < 0) ill = 0;         // cosine a hair above one
         ill = (ill + 16384) >>> 15;
         if (ill > 65536) ill = 65536; // cosine a hair below minus one
         mage = ({32'd0, age_ang} * SYN_Q24 + (64'd1 << 39)) >> 40;
         r.position = age_ang[31:16];
         r.lit      = ill[16:0];
         r.age_days = mage[20:0];
         return r;
      endfunction

      function void note_date(input logic [47:0] jd);
         phases_due.push_back(phase_of(jd));
      endfunction

      task check_phase(input logic [55:0] data);
         phase_type got, want;
         got = data[53:0];
         if (phases_due.size() == 0) begin
            report($sformatf("unexpected result %h", data));
            return;
         end
         want = phases_due.pop_front();
         if (got.position !== want.position)
            report($sformatf("cycle_position %0d, want %0d", got.position, want.position));
         if (got.lit !== want.lit)
            report($sformatf("illuminated_fraction %0d, want %0d", got.lit, want.lit));
         if (got.age_days !== want.age_days)
            report($sformatf("moon_age %0d, want %0d", got.age_days, want.age_days));
         if (data[55:54] !== 2'b00)
            report($sformatf("pad bits %b", data[55:54]));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // [47:0] julian_date
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;        // [15:0] position, [32:16] lit, [53:33] age

   phase_scoreboard sb = new();
   bit quiet = 0;   // no idling on either side while set
   int idle_cycles = 0;

   moon_phase_from_date i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // Stall the result side about a quarter of the time, except in the quiet window.
   always @(negedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
   end

   // Check each result transfer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_phase(rsp_tdata);
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one date: idle at random first, then hold it until the transfer.
   task automatic send_date(input logic [47:0] jd);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= jd;
      do @(posedge clock); while (!req_tready);
      sb.note_date(jd);
   endtask

   function automatic logic [47:0] jd_q24(input longint days, input int frac);
      return 48'(days << 24) + 48'(frac);
   endfunction

   function automatic logic [47:0] random_date();
      logic [47:0] v;
      v = 48'({$urandom, $urandom});
      case ($urandom_range(3))
         0, 1: v = jd_q24($urandom_range(2500000, 2400000), $urandom_range(24'hFFFFFF));
         2:    v = jd_q24($urandom_range(2444238 + 400, 2444238 - 400),
                          $urandom_range(24'hFFFFFF));
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      logic [47:0] dir [$];
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // extremes of the field, epoch and neighbors, dates before the epoch
      dir = '{48'd0, 48'd1, 48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
              48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, EPOCH_Q24[47:0],
              EPOCH_Q24[47:0] - 48'd1, EPOCH_Q24[47:0] + 48'd1,
              jd_q24(2444000, 0), jd_q24(2000000, 123456),
              // near new moons and full moons, to reach the clamps
              jd_q24(2451550, 24'h1A0000), jd_q24(2451550, 24'h1B0000),
              jd_q24(2451565, 24'h340000), jd_q24(2451565, 24'h300000),
              jd_q24(2460000, 24'h800000), jd_q24(2415020, 24'h800000)};
      foreach (dir[i]) send_date(dir[i]);

      for (int n = 0; n < ITEM_COUNT; n++) begin
         quiet = (n >= 500 && n < 700);
         send_date(random_date());
      end
      quiet = 0;
      @(negedge clock);
      req_tvalid <= 0;

      while (sb.phases_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+src
src/mpfd_pkg.sv
src/moon_phase_from_date.sv
tb/sv/moon_phase_from_date_test.sv
